/* hw/rtl/tournament_branch_predictor_assert.svh */
// ----------------------------------------------------------------------------
// Tournament branch predictor assertion macros
// Shared concurrent-check wrappers, clocked on clock, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH

// same-cycle implication
`define TBP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TBP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/tbp_pkg.sv */
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared constants, types and counter/history helpers for the predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package tbp_pkg;

   localparam int MAX_INDEX_BITS = 12;
   localparam int HIST_ENTRIES   = 128;
   localparam int HIST_SEL_BITS  = $clog2(HIST_ENTRIES);
   localparam int TABLE_DEPTH    = 1 << MAX_INDEX_BITS;
   localparam int CTR_W          = 2;
   localparam int PC_W           = 12;

   typedef logic [MAX_INDEX_BITS-1:0] idx_type;
   typedef logic [CTR_W-1:0]          ctr_type;

   localparam ctr_type CTR_MAX   = 2'd3;
   localparam ctr_type CTR_MIN   = 2'd0;
   localparam ctr_type CTR_RESET = 2'd3;

   // table_size_code values
   localparam logic [1:0] SIZE_128  = 2'd0;
   localparam logic [1:0] SIZE_1024 = 2'd1;
   localparam logic [1:0] SIZE_4096 = 2'd2;
   localparam logic [1:0] SIZE_RESET = SIZE_1024;

   localparam int W_128  = 7;
   localparam int W_1024 = 10;
   localparam int W_4096 = 12;

   typedef struct packed {
      logic prediction;
      logic global_guess;
      logic local_guess;
      logic chose_global;
   } guess_type;

   typedef struct packed {
      logic    chooser_we;
      ctr_type chooser_ctr;
      ctr_type global_ctr;
      ctr_type local_ctr;
   } update_type;

   // low-bit mask of the index width, capped at the table size
   function automatic idx_type width_mask(input logic [1:0] code);
      int w;
      case (code)
         SIZE_128:  w = W_128;
         SIZE_1024: w = W_1024;
         default:   w = W_4096;
      endcase
      if (w > MAX_INDEX_BITS) w = MAX_INDEX_BITS;
      return idx_type'((64'd1 << w) - 64'd1);
   endfunction

   function automatic ctr_type sat_step(input ctr_type c, input logic up);
      if (up) return (c == CTR_MAX) ? CTR_MAX : ctr_type'(c + 1'b1);
      return (c == CTR_MIN) ? CTR_MIN : ctr_type'(c - 1'b1);
   endfunction

   // shift right within the mask, outcome into the top masked bit
   function automatic idx_type shift_in(input idx_type h, input idx_type mask,
                                        input logic t);
      idx_type top;
      top = mask & ~(mask >> 1);
      return ((h & mask) >> 1) | (t ? top : '0);
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/tournament_branch_predictor.sv */
// ----------------------------------------------------------------------------
// tournament_branch_predictor
// Local/gshare tournament predictor with 2-bit counters in block RAM.
// ----------------------------------------------------------------------------
// Usage: issue a branch word with start while busy is low. Its result shows on
// the rsp_ ports for one cycle under rsp_valid: the word passes the HIST and
// EVAL states and the strobe comes from a register written as EVAL ends. There is no
// way to hold it off: sample it that cycle. A new word can start only once the
// last one is through: the two dependent RAM reads (local history, then the
// local counter it points at) and the write-back in EVAL come first. After reset,
// busy stays high while a clear pass walks all 4096 entries, filling every counter
// with 3 and every local history with 0.
// csr_ready is always high; change table_size_code only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tournament_branch_predictor_assert.svh"

module tournament_branch_predictor (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // branch request
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [tbp_pkg::PC_W-1:0] req_pc,
   input  wire logic                     req_taken,
   // result strobe
   output logic                          rsp_valid,
   output logic                          rsp_prediction,
   output logic                          rsp_global_guess,
   output logic                          rsp_local_guess,
   output logic                          rsp_chose_global,
   // configuration
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [1:0]               csr_table_size_code
);

   // CLEAR: reset sweep; IDLE: take a word; HIST: history read back, fetch
   // local counter; EVAL: all counters in hand, predict and write back.
   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_HIST  = 4'b0100,
      ST_EVAL  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   tbp_pkg::idx_type clr_ff, clr_in;
   logic [1:0]       size_ff, size_in;
   tbp_pkg::idx_type ghist_ff, ghist_in;

   // per-word registers (payload, no reset)
   logic [tbp_pkg::HIST_SEL_BITS-1:0] hsel_ff;
   logic             taken_ff;
   tbp_pkg::idx_type mask_ff;
   tbp_pkg::idx_type low_ff;
   tbp_pkg::idx_type gidx_ff;
   tbp_pkg::idx_type lidx_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   tbp_pkg::guess_type rsp_ff;

   logic             accept;
   logic             clearing;
   logic             eval;
   tbp_pkg::idx_type acc_mask;
   tbp_pkg::idx_type acc_low;
   tbp_pkg::idx_type acc_gidx;
   tbp_pkg::idx_type lidx_rd;

   tbp_pkg::idx_type hist_q;
   tbp_pkg::ctr_type lctr_q;
   tbp_pkg::ctr_type gctr_q;
   tbp_pkg::ctr_type cctr_q;

   tbp_pkg::guess_type  guess;
   tbp_pkg::update_type upd;

   assign accept   = start & (state_ff == ST_IDLE);
   assign clearing = (state_ff == ST_CLEAR);
   assign eval     = (state_ff == ST_EVAL);
   assign busy     = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // indexes for the words read at the start edge
   assign acc_mask = tbp_pkg::width_mask(size_ff);
   assign acc_low  = tbp_pkg::idx_type'(req_pc) & acc_mask;
   assign acc_gidx = (ghist_ff & acc_mask) ^ acc_low;
   assign lidx_rd  = hist_q & mask_ff;

   // ---------------------------------------------------------------------
   // control
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == tbp_pkg::idx_type'(tbp_pkg::TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) state_in = ST_HIST;
         end
         ST_HIST: state_in = ST_EVAL;
         ST_EVAL: state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   assign size_in      = csr_valid ? csr_table_size_code : size_ff;
   assign ghist_in     = eval ? tbp_pkg::shift_in(ghist_ff, mask_ff, taken_ff) : ghist_ff;
   assign rsp_valid_in = eval;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         size_ff      <= tbp_pkg::SIZE_RESET;
         ghist_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         size_ff      <= size_in;
         ghist_ff     <= ghist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // per-word capture
   always_ff @(posedge clock) begin
      if (accept) begin
         hsel_ff  <= req_pc[tbp_pkg::HIST_SEL_BITS-1:0];
         taken_ff <= req_taken;
         mask_ff  <= acc_mask;
         low_ff   <= acc_low;
         gidx_ff  <= acc_gidx;
      end
      if (state_ff == ST_HIST) begin
         lidx_ff <= lidx_rd;
      end
      if (eval) begin
         rsp_ff <= guess;
      end
   end

   // ---------------------------------------------------------------------
   // tables
   // ---------------------------------------------------------------------
   tbp_ram #(
      .WIDTH ($bits(tbp_pkg::idx_type)),
      .DEPTH (tbp_pkg::HIST_ENTRIES)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (clearing | eval),
      .wr_addr (clearing ? clr_ff[tbp_pkg::HIST_SEL_BITS-1:0] : hsel_ff),
      .wr_data (clearing ? '0 : tbp_pkg::shift_in(hist_q, mask_ff, taken_ff)),
      .rd_en   (accept),
      .rd_addr (req_pc[tbp_pkg::HIST_SEL_BITS-1:0]),
      .rd_data (hist_q)
   );

   // local counters: read in HIST, addressed by the history that came back
   tbp_ram #(
      .WIDTH (tbp_pkg::CTR_W),
      .DEPTH (tbp_pkg::TABLE_DEPTH)
   ) u_local_ram (
      .clock   (clock),
      .wr_en   (clearing | eval),
      .wr_addr (clearing ? clr_ff : lidx_ff),
      .wr_data (clearing ? tbp_pkg::CTR_RESET : upd.local_ctr),
      .rd_en   (state_ff == ST_HIST),
      .rd_addr (lidx_rd),
      .rd_data (lctr_q)
   );

   tbp_ram #(
      .WIDTH (tbp_pkg::CTR_W),
      .DEPTH (tbp_pkg::TABLE_DEPTH)
   ) u_global_ram (
      .clock   (clock),
      .wr_en   (clearing | eval),
      .wr_addr (clearing ? clr_ff : gidx_ff),
      .wr_data (clearing ? tbp_pkg::CTR_RESET : upd.global_ctr),
      .rd_en   (accept),
      .rd_addr (acc_gidx),
      .rd_data (gctr_q)
   );

   tbp_ram #(
      .WIDTH (tbp_pkg::CTR_W),
      .DEPTH (tbp_pkg::TABLE_DEPTH)
   ) u_chooser_ram (
      .clock   (clock),
      .wr_en   (clearing | (eval & upd.chooser_we)),
      .wr_addr (clearing ? clr_ff : low_ff),
      .wr_data (clearing ? tbp_pkg::CTR_RESET : upd.chooser_ctr),
      .rd_en   (accept),
      .rd_addr (acc_low),
      .rd_data (cctr_q)
   );

   tbp_train u_train (
      .ctr_local   (lctr_q),
      .ctr_global  (gctr_q),
      .ctr_chooser (cctr_q),
      .taken       (taken_ff),
      .guess       (guess),
      .upd         (upd)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_prediction   = rsp_ff.prediction;
   assign rsp_global_guess = rsp_ff.global_guess;
   assign rsp_local_guess  = rsp_ff.local_guess;
   assign rsp_chose_global = rsp_ff.chose_global;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   `TBP_ASSERT_NXT(a_start_walks, accept, state_ff == ST_HIST, "start did not enter lookup")
   `TBP_ASSERT_NXT(a_eval_strobes, eval, rsp_valid_ff, "evaluation gave no result strobe")
   `TBP_ASSERT_IMP(a_strobe_idle, rsp_valid_ff, state_ff == ST_IDLE, "result strobe while busy")
   `TBP_ASSERT_IMP(a_pick_side, rsp_valid_ff,
      rsp_prediction == (rsp_chose_global ? rsp_global_guess : rsp_local_guess),
      "prediction does not follow the chooser")

endmodule

`default_nettype wire

/* hw/rtl/tbp_ram.sv */
// ----------------------------------------------------------------------------
// tbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/tbp_train.sv */
// ----------------------------------------------------------------------------
// tbp_train
// Guesses from the three counters and their trained next values.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_train (
   input  wire tbp_pkg::ctr_type    ctr_local,
   input  wire tbp_pkg::ctr_type    ctr_global,
   input  wire tbp_pkg::ctr_type    ctr_chooser,
   input  wire logic                taken,
   output tbp_pkg::guess_type       guess,
   output tbp_pkg::update_type      upd
);

   logic l_guess;
   logic g_guess;
   logic g_ok;
   logic l_ok;

   // taken when counter > 1, i.e. upper bit set
   assign l_guess = ctr_local[tbp_pkg::CTR_W-1];
   assign g_guess = ctr_global[tbp_pkg::CTR_W-1];
   assign g_ok    = (g_guess == taken);
   assign l_ok    = (l_guess == taken);

   always_comb begin
      guess.chose_global = ctr_chooser[tbp_pkg::CTR_W-1];
      guess.global_guess = g_guess;
      guess.local_guess  = l_guess;
      guess.prediction   = guess.chose_global ? g_guess : l_guess;

      // chooser only moves when exactly one side was right
      upd.chooser_we  = g_ok ^ l_ok;
      upd.chooser_ctr = tbp_pkg::sat_step(ctr_chooser, g_ok);
      upd.global_ctr  = tbp_pkg::sat_step(ctr_global, taken);
      upd.local_ctr   = tbp_pkg::sat_step(ctr_local, taken);
   end

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: tournament_branch_predictor testbench
// Sends branch words through the start/busy handshake and predicts each
// result with a local/gshare/chooser model of its own. Every rsp_valid
// strobe is checked field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   // code 3 is not a listed size; the block treats it as the 4096 table
   localparam logic [1:0] SIZE_UNUSED = 2'd3;
   localparam int HOT_BRANCHES = 16;

   // outcome shapes for the hot branches of a random phase
   typedef enum logic [1:0] {
      PAT_LOOP,
      PAT_ALTERNATE,
      PAT_BIASED_TAKEN,
      PAT_BIASED_NOT
   } pattern_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic [tbp_pkg::PC_W-1:0] req_pc = '0;
   logic                     req_taken = 1'b0;
   logic                     csr_valid = 1'b0;
   logic [1:0]               csr_table_size_code = tbp_pkg::SIZE_RESET;
   logic                     busy;
   logic                     rsp_valid;
   logic                     rsp_prediction;
   logic                     rsp_global_guess;
   logic                     rsp_local_guess;
   logic                     rsp_chose_global;
   logic                     csr_ready;

   // predictor state, kept in step with every accepted word
   logic [1:0]       size_code;
   tbp_pkg::idx_type local_hist [tbp_pkg::HIST_ENTRIES];
   tbp_pkg::ctr_type local_ctr [tbp_pkg::TABLE_DEPTH];
   tbp_pkg::ctr_type global_ctr [tbp_pkg::TABLE_DEPTH];
   tbp_pkg::ctr_type chooser_ctr [tbp_pkg::TABLE_DEPTH];
   tbp_pkg::idx_type global_hist;

   // guesses predicted for accepted words, oldest first
   tbp_pkg::guess_type pending_guesses [$];
   tbp_pkg::guess_type oldest_guess;
   int                 errors = 0;
   bit                 gaps_on = 1'b1;

   // hot branch pool of the current random phase
   logic [tbp_pkg::PC_W-1:0] hot_pc [HOT_BRANCHES];
   pattern_type              hot_kind [HOT_BRANCHES];
   int                       hot_trip [HOT_BRANCHES];
   int                       hot_iter [HOT_BRANCHES];

   always #2 clock = ~clock;

   tournament_branch_predictor dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_pc              (req_pc),
      .req_taken           (req_taken),
      .rsp_valid           (rsp_valid),
      .rsp_prediction      (rsp_prediction),
      .rsp_global_guess    (rsp_global_guess),
      .rsp_local_guess     (rsp_local_guess),
      .rsp_chose_global    (rsp_chose_global),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_table_size_code (csr_table_size_code)
   );

   // ---------------------------------------------------------------------
   // Branch predictor model
   // ---------------------------------------------------------------------

   // state right after the clear pass: counters at 3, histories at 0
   function automatic void clear_predictor();
      size_code   = tbp_pkg::SIZE_RESET;
      global_hist = '0;
      for (int i = 0; i < tbp_pkg::HIST_ENTRIES; i++) local_hist[i] = '0;
      for (int i = 0; i < tbp_pkg::TABLE_DEPTH; i++) begin
         local_ctr[i]   = tbp_pkg::CTR_RESET;
         global_ctr[i]  = tbp_pkg::CTR_RESET;
         chooser_ctr[i] = tbp_pkg::CTR_RESET;
      end
   endfunction

   // 2-bit saturating counter, one step toward the outcome
   function automatic tbp_pkg::ctr_type bump_counter(input tbp_pkg::ctr_type c,
                                                     input logic up);
      if (up) return (c == 2'd3) ? c : c + 2'd1;
      return (c == 2'd0) ? c : c - 2'd1;
   endfunction

   // history shifts right within the live width, outcome lands in its top bit;
   // anything above the width is dropped
   function automatic tbp_pkg::idx_type history_push(input tbp_pkg::idx_type h,
                                                     input tbp_pkg::idx_type mask,
                                                     input int unsigned w,
                                                     input logic t);
      return ((h & mask) >> 1) | (tbp_pkg::idx_type'(t) << (w - 1));
   endfunction

   // guesses from the state as it stands, then train with the real outcome
   function automatic tbp_pkg::guess_type predict_and_train(
         input logic [tbp_pkg::PC_W-1:0] pc, input logic taken);
      int unsigned                       w;
      tbp_pkg::idx_type                  mask;
      tbp_pkg::idx_type                  low;
      tbp_pkg::idx_type                  lidx;
      tbp_pkg::idx_type                  gidx;
      logic [tbp_pkg::HIST_SEL_BITS-1:0] lsel;
      logic                              g_right;
      logic                              l_right;
      tbp_pkg::guess_type                g;
      case (size_code)
         tbp_pkg::SIZE_128:  w = tbp_pkg::W_128;
         tbp_pkg::SIZE_1024: w = tbp_pkg::W_1024;
         default:            w = tbp_pkg::W_4096;
      endcase
      mask = tbp_pkg::idx_type'((1 << w) - 1);
      low  = tbp_pkg::idx_type'(pc) & mask;
      lsel = pc[tbp_pkg::HIST_SEL_BITS-1:0];          // pc mod history entries
      lidx = local_hist[lsel] & mask;
      gidx = (global_hist & mask) ^ low;

      g.local_guess  = local_ctr[lidx] > 2'd1;
      g.global_guess = global_ctr[gidx] > 2'd1;
      g.chose_global = chooser_ctr[low] > 2'd1;
      g.prediction   = g.chose_global ? g.global_guess : g.local_guess;

      // chooser moves only when exactly one component was right
      g_right = (g.global_guess == taken);
      l_right = (g.local_guess == taken);
      if (g_right != l_right) chooser_ctr[low] = bump_counter(chooser_ctr[low], g_right);

      global_ctr[gidx] = bump_counter(global_ctr[gidx], taken);
      global_hist      = history_push(global_hist, mask, w, taken);
      local_ctr[lidx]  = bump_counter(local_ctr[lidx], taken);
      local_hist[lsel] = history_push(local_hist[lsel], mask, w, taken);
      return g;
   endfunction

   // ---------------------------------------------------------------------
   // Result checker: the strobe lasts one cycle and cannot be held off, so
   // every cycle with rsp_valid high is a word to check.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_guesses.size() == 0) begin
            $error("result word with no prediction pending");
            errors++;
         end else begin
            oldest_guess = pending_guesses.pop_front();
            if (rsp_prediction !== oldest_guess.prediction) begin
               $error("prediction: expected %0b, got %0b",
                      oldest_guess.prediction, rsp_prediction);
               errors++;
            end
            if (rsp_global_guess !== oldest_guess.global_guess) begin
               $error("global_guess: expected %0b, got %0b",
                      oldest_guess.global_guess, rsp_global_guess);
               errors++;
            end
            if (rsp_local_guess !== oldest_guess.local_guess) begin
               $error("local_guess: expected %0b, got %0b",
                      oldest_guess.local_guess, rsp_local_guess);
               errors++;
            end
            if (rsp_chose_global !== oldest_guess.chose_global) begin
               $error("chose_global: expected %0b, got %0b",
                      oldest_guess.chose_global, rsp_chose_global);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // Offer one branch word and hold it until an edge sees start with busy low.
   // With no gap drawn, start stays high so the next word follows at once.
   task automatic send_branch(input logic [tbp_pkg::PC_W-1:0] pc, input logic taken);
      start     <= 1'b1;
      req_pc    <= pc;
      req_taken <= taken;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_guesses.push_back(predict_and_train(pc, taken));
      // idle gap: geometric length, so start comes back at varying points of the busy phase
      if (gaps_on && $urandom_range(99) < 32) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 32);
      end
   endtask

   // stop sending and wait until every predicted word has come back
   task automatic wait_results_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_guesses.size() != 0 || busy) @(posedge clock);
   endtask

   // size register may only change while the block is idle
   task automatic write_table_size(input logic [1:0] code);
      wait_results_drained();
      csr_valid           <= 1'b1;
      csr_table_size_code <= code;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      size_code = code;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // default size: pc extremes, history select wrap at 128, and a branch
   // driven not-taken until its local counter falls below the taken threshold
   task automatic test_directed_extremes();
      send_branch(12'h000, 1'b1);
      send_branch(12'hFFF, 1'b0);
      send_branch(12'hFFF, 1'b0);
      send_branch(12'hFFF, 1'b0);
      send_branch(12'h07F, 1'b1);
      send_branch(12'h080, 1'b0);
      send_branch(12'hAAA, 1'b1);
      send_branch(12'h555, 1'b0);
   endtask

   // smallest and largest tables, then the unused code
   task automatic test_size_codes();
      write_table_size(tbp_pkg::SIZE_128);
      send_branch(12'hF80, 1'b1);
      send_branch(12'h07F, 1'b0);
      send_branch(12'hFFF, 1'b0);
      send_branch(12'h000, 1'b1);
      write_table_size(tbp_pkg::SIZE_4096);
      send_branch(12'hFFF, 1'b1);
      send_branch(12'h800, 1'b0);
      send_branch(12'hFFF, 1'b0);
      write_table_size(SIZE_UNUSED);
      send_branch(12'hFFF, 1'b1);
      send_branch(12'h800, 1'b1);
      send_branch(12'hFFF, 1'b0);
   endtask

   // histories survive a size change; a push after shrinking clears their upper bits
   task automatic test_size_change_keeps_history();
      write_table_size(tbp_pkg::SIZE_4096);
      send_branch(12'hABC, 1'b1);
      send_branch(12'hABC, 1'b1);
      write_table_size(tbp_pkg::SIZE_128);
      send_branch(12'h03C, 1'b0);
      write_table_size(tbp_pkg::SIZE_4096);
      send_branch(12'hABC, 1'b1);
   endtask

   // Mostly a pool of hot branches with loop, alternating and biased outcomes
   // (what a real fetch stream looks like, so the chooser actually moves),
   // a few flipped outcomes, and random noise branches over the full pc range.
   task automatic test_random_branches(input logic [1:0] code, input int count,
                                       input bit no_idle);
      int                       pick;
      logic [tbp_pkg::PC_W-1:0] pc;
      logic                     taken;
      write_table_size(code);
      gaps_on = !no_idle;
      for (int k = 0; k < HOT_BRANCHES; k++) begin
         hot_pc[k]   = $urandom_range(4095);
         hot_kind[k] = pattern_type'($urandom_range(3));
         hot_trip[k] = $urandom_range(2, 9);
         hot_iter[k] = 0;
      end
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 80) begin
            pick = $urandom_range(HOT_BRANCHES - 1);
            pc   = hot_pc[pick];
            case (hot_kind[pick])
               PAT_LOOP:         taken = (hot_iter[pick] % hot_trip[pick]) !=
                                         (hot_trip[pick] - 1);
               PAT_ALTERNATE:    taken = hot_iter[pick][0];
               PAT_BIASED_TAKEN: taken = $urandom_range(99) < 88;
               default:          taken = $urandom_range(99) < 12;
            endcase
            hot_iter[pick]++;
            if ($urandom_range(99) < 4) taken = !taken;   // broken pattern
         end else begin
            pc    = $urandom_range(4095);
            taken = $urandom_range(1);
         end
         send_branch(pc, taken);
         // mid-phase pause until the pipe is empty
         if (i == count / 2) wait_results_drained();
      end
      gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Run
   // ---------------------------------------------------------------------
   initial begin
      clear_predictor();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // the clear pass keeps busy high; the first word simply waits on it
      test_directed_extremes();
      test_size_codes();
      test_size_change_keeps_history();
      test_random_branches(tbp_pkg::SIZE_1024, 520, 1'b0);
      test_random_branches(tbp_pkg::SIZE_128, 420, 1'b1);     // stretch with no idling
      test_random_branches(tbp_pkg::SIZE_4096, 400, 1'b0);
      test_random_branches(SIZE_UNUSED, 200, 1'b0);
      wait_results_drained();
      // leave room for any stray strobe
      repeat (8) @(posedge clock);
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog, far beyond a correct run including the clear pass
   initial begin
      #1_600_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
